@@ hw/rtl/sfbd_pkg.sv @@
// ---------------------------------------------------------------------------
// sfbd_pkg
// Shared types and constants of the stream frame boundary detector.
// ---------------------------------------------------------------------------
package sfbd_pkg;

    localparam int LENGTH_BITS_DEFAULT = 32;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_BODY,
        PH_LINE
    } phase_t;

    localparam logic [1:0] MODE_LEN2 = 2'd0;
    localparam logic [1:0] MODE_TEXT = 2'd2;

    localparam logic [2:0] HDR_LEN2     = 3'd2;
    localparam logic [2:0] HDR_LEN4     = 3'd4;
    localparam logic [2:0] PREFIX_LEN   = 3'd3;
    localparam logic [2:0] TOKEN_MAX    = 3'd7;
    localparam logic [2:0] TOKEN_THIRD  = 3'd3;
    localparam logic [2:0] TOKEN_FOURTH = 3'd4;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    localparam int MSG_TRAILER = 2;

    typedef struct packed {
        logic first;
        logic last;
        logic hdr;
    } flags_t;

    // lower-case "msg" prefix letters
    function automatic logic [7:0] prefix_char(input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = 8'h6D;
            2'd1:    c = 8'h73;
            default: c = 8'h67;
        endcase
        return c;
    endfunction

endpackage

@@ hw/rtl/sfbd_in_stage.sv @@
// ---------------------------------------------------------------------------
// sfbd_in_stage
// Input register: holds one accepted byte until the framer consumes it.
// ---------------------------------------------------------------------------
module sfbd_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_value,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] byte_data
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_byte_value;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

@@ hw/rtl/sfbd_core.sv @@
// ---------------------------------------------------------------------------
// sfbd_core
// Framing state machine: mode register, header/body counting, MSG line scan.
// ---------------------------------------------------------------------------
module sfbd_core #(
    parameter int LENGTH_BITS = sfbd_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic [1:0]        cfg_data,
    input  logic              step,
    input  logic [7:0]        byte_in,
    output sfbd_pkg::flags_t  flags
);
    import sfbd_pkg::*;

    localparam int REM_W = LENGTH_BITS + 1;
    localparam int SUM_W = LENGTH_BITS + 4;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    logic [1:0]             mode_reg;
    phase_t                 phase_reg, phase_next;
    logic [2:0]             hp_reg, hp_next, hp_eff;
    logic [31:0]            acc_reg, acc_next, acc_eff;
    logic [REM_W-1:0]       rem_reg, rem_next, rem_eff, rem_dec;
    logic                   pcr_reg, pcr_next, pcr_eff;
    logic                   pm_reg, pm_next, pm_eff;
    logic [2:0]             tc_reg, tc_next, tc_eff, tc_tok;
    logic                   it_reg, it_next, it_eff;
    logic                   dl_reg, dl_next, dl_eff, dl_tok;
    logic [LENGTH_BITS-1:0] v3_reg, v3_next, v3_eff;
    logic [LENGTH_BITS-1:0] v4_reg, v4_next, v4_eff;

    logic                   text;
    logic                   start;
    phase_t                 phase_eff;
    logic [2:0]             hlen;
    logic [31:0]            acc_shift;
    logic [LENGTH_BITS-1:0] len_sat;
    logic [LENGTH_BITS-1:0] count_sel;
    logic                   is_ws;
    logic                   is_digit;
    logic [3:0]             digit;
    logic [LENGTH_BITS-1:0] dig_src;
    logic [SUM_W-1:0]       dig_sum;
    logic [LENGTH_BITS-1:0] dig_sat;

    assign text  = (mode_reg >= MODE_TEXT);
    assign start = (phase_reg == PH_IDLE);
    assign hlen  = (mode_reg == MODE_LEN2) ? HDR_LEN2 : HDR_LEN4;

    // a new frame starts from cleared state
    always_comb begin
        if (start) begin
            phase_eff = text ? PH_LINE : PH_HEADER;
            hp_eff    = '0;
            acc_eff   = '0;
            rem_eff   = '0;
            pcr_eff   = 1'b0;
            pm_eff    = text;
            tc_eff    = '0;
            it_eff    = 1'b0;
            dl_eff    = 1'b0;
            v3_eff    = '0;
            v4_eff    = '0;
        end else begin
            phase_eff = phase_reg;
            hp_eff    = hp_reg;
            acc_eff   = acc_reg;
            rem_eff   = rem_reg;
            pcr_eff   = pcr_reg;
            pm_eff    = pm_reg;
            tc_eff    = tc_reg;
            it_eff    = it_reg;
            dl_eff    = dl_reg;
            v3_eff    = v3_reg;
            v4_eff    = v4_reg;
        end
    end

    assign acc_shift = {acc_eff[23:0], byte_in};
    assign len_sat   = (acc_shift > 32'(LEN_MAX)) ? LEN_MAX : acc_shift[LENGTH_BITS-1:0];
    assign rem_dec   = (rem_eff != '0) ? rem_eff - REM_W'(1) : rem_eff;
    assign count_sel = (tc_eff >= TOKEN_FOURTH) ? v4_eff : v3_eff;

    assign is_ws    = (byte_in == CHAR_SPACE) || (byte_in >= CHAR_TAB && byte_in <= CHAR_CR);
    assign is_digit = (byte_in >= CHAR_ZERO) && (byte_in <= CHAR_NINE);
    assign digit    = 4'(byte_in - CHAR_ZERO);

    // token bookkeeping for a non-whitespace byte
    assign tc_tok = it_eff ? tc_eff : ((tc_eff < TOKEN_MAX) ? tc_eff + 3'd1 : tc_eff);
    assign dl_tok = it_eff ? dl_eff : 1'b1;

    // shared decimal accumulate: v*10 + d, saturating
    assign dig_src = (tc_tok == TOKEN_THIRD) ? v3_eff : v4_eff;
    assign dig_sum = (SUM_W'(dig_src) << 3) + (SUM_W'(dig_src) << 1) + SUM_W'(digit);
    assign dig_sat = (dig_sum > SUM_W'(LEN_MAX)) ? LEN_MAX : dig_sum[LENGTH_BITS-1:0];

    always_comb begin
        phase_next  = phase_eff;
        hp_next     = hp_eff;
        acc_next    = acc_eff;
        rem_next    = rem_eff;
        pcr_next    = pcr_eff;
        pm_next     = pm_eff;
        tc_next     = tc_eff;
        it_next     = it_eff;
        dl_next     = dl_eff;
        v3_next     = v3_eff;
        v4_next     = v4_eff;
        flags.first = start;
        flags.last  = 1'b0;
        flags.hdr   = 1'b0;

        unique case (phase_eff)
            PH_HEADER: begin
                flags.hdr = 1'b1;
                acc_next  = acc_shift;
                hp_next   = hp_eff + 3'd1;
                if (hp_next >= hlen) begin
                    if (len_sat == '0) begin
                        flags.last = 1'b1;
                        phase_next = PH_IDLE;
                    end else begin
                        rem_next   = REM_W'(len_sat);
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                rem_next = rem_dec;
                if (rem_dec == '0) begin
                    flags.last = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            PH_LINE: begin
                flags.hdr = 1'b1;
                if (pcr_eff && byte_in == CHAR_LF) begin
                    pcr_next = 1'b0;
                    if (pm_eff) begin
                        rem_next   = REM_W'(count_sel) + REM_W'(MSG_TRAILER);
                        phase_next = PH_BODY;
                    end else begin
                        flags.last = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end else begin
                    if (hp_eff < PREFIX_LEN) begin
                        if ((byte_in | CASE_BIT) != prefix_char(hp_eff[1:0])) begin
                            pm_next = 1'b0;
                        end
                        hp_next = hp_eff + 3'd1;
                    end else if (pm_eff) begin
                        if (is_ws) begin
                            it_next = 1'b0;
                        end else begin
                            it_next = 1'b1;
                            tc_next = tc_tok;
                            dl_next = dl_tok;
                            if (dl_tok && (tc_tok == TOKEN_THIRD || tc_tok == TOKEN_FOURTH)) begin
                                if (is_digit) begin
                                    if (tc_tok == TOKEN_THIRD) begin
                                        v3_next = dig_sat;
                                    end else begin
                                        v4_next = dig_sat;
                                    end
                                end else begin
                                    dl_next = 1'b0;
                                end
                            end
                        end
                    end
                    pcr_next = (byte_in == CHAR_CR);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_LEN2;
            phase_reg <= PH_IDLE;
            hp_reg    <= '0;
            acc_reg   <= '0;
            rem_reg   <= '0;
            pcr_reg   <= 1'b0;
            pm_reg    <= 1'b0;
            tc_reg    <= '0;
            it_reg    <= 1'b0;
            dl_reg    <= 1'b0;
            v3_reg    <= '0;
            v4_reg    <= '0;
        end else if (cfg_valid) begin
            mode_reg  <= cfg_data;
            phase_reg <= PH_IDLE;
        end else if (step) begin
            phase_reg <= phase_next;
            hp_reg    <= hp_next;
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
            pcr_reg   <= pcr_next;
            pm_reg    <= pm_next;
            tc_reg    <= tc_next;
            it_reg    <= it_next;
            dl_reg    <= dl_next;
            v3_reg    <= v3_next;
            v4_reg    <= v4_next;
        end
    end

endmodule

@@ hw/rtl/sfbd_out_stage.sv @@
// ---------------------------------------------------------------------------
// sfbd_out_stage
// Result register: holds one marked byte until the sink takes it.
// ---------------------------------------------------------------------------
module sfbd_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load_valid,
    output logic             can_load,
    input  logic [7:0]       load_byte,
    input  sfbd_pkg::flags_t load_flags,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_data_byte,
    output logic             m_frame_first,
    output logic             m_frame_last,
    output logic             m_header_byte
);
    import sfbd_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    flags_t     flags_reg;

    assign can_load   = !valid_reg || m_ready;
    assign valid_next = can_load ? load_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (can_load && load_valid) begin
            byte_reg  <= load_byte;
            flags_reg <= load_flags;
        end
    end

    assign m_valid       = valid_reg;
    assign m_data_byte   = byte_reg;
    assign m_frame_first = flags_reg.first;
    assign m_frame_last  = flags_reg.last;
    assign m_header_byte = flags_reg.hdr;

endmodule

@@ hw/rtl/stream_frame_boundary_detector.sv @@
// ---------------------------------------------------------------------------
// stream_frame_boundary_detector
// Marks frame start, end and header bytes in a received byte stream.
// Path: an accepted byte passes the input register, then the result register.
// Throughput: one byte per cycle while the sink takes results; the framer updates its state once per byte.
// Reset: synchronous active-low aresetn clears the valid flags and framer state; framing mode -> 0.
// A configuration write drops any frame in progress.
// ---------------------------------------------------------------------------
module stream_frame_boundary_detector #(
    parameter int LENGTH_BITS = sfbd_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data_byte,
    output logic       m_frame_first,
    output logic       m_frame_last,
    output logic       m_header_byte
);
    import sfbd_pkg::*;

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       can_load;
    logic       advance;
    flags_t     flags;

    assign cfg_ready = 1'b1;
    assign advance   = byte_valid && can_load;

    sfbd_in_stage u_in (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_byte_value (s_byte_value),
        .advance      (advance),
        .byte_valid   (byte_valid),
        .byte_data    (byte_data)
    );

    sfbd_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .step      (advance),
        .byte_in   (byte_data),
        .flags     (flags)
    );

    sfbd_out_stage u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load_valid    (byte_valid),
        .can_load      (can_load),
        .load_byte     (byte_data),
        .load_flags    (flags),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data_byte   (m_data_byte),
        .m_frame_first (m_frame_first),
        .m_frame_last  (m_frame_last),
        .m_header_byte (m_header_byte)
    );

endmodule

@@ hw/rtl/sfbd_checker.sv @@
// ---------------------------------------------------------------------------
// sfbd_checker
// Port-level checks of the frame boundary detector, bound to the top level.
// ---------------------------------------------------------------------------
module sfbd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       cfg_valid,
    input logic       cfg_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_data_byte,
    input logic       m_frame_first,
    input logic       m_frame_last,
    input logic       m_header_byte
);
    logic pending_first_reg;
    logic pending_first_next;
    logic out_take;

    assign out_take = m_valid && m_ready;

    // next delivered byte must open a frame
    always_comb begin
        pending_first_next = pending_first_reg;
        if (out_take) begin
            pending_first_next = m_frame_last;
        end
        if (cfg_valid && cfg_ready) begin
            pending_first_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_first_reg <= 1'b1;
        end else begin
            pending_first_reg <= pending_first_next;
        end
    end

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data_byte) && $stable(m_frame_first)
            && $stable(m_frame_last) && $stable(m_header_byte))
        else $error("stalled result changed");

    a_first_follows_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_take |-> (m_frame_first == pending_first_reg))
        else $error("frame start does not follow frame end");

    a_first_is_header: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_first |-> m_header_byte)
        else $error("frame start byte not marked as header");

endmodule

bind stream_frame_boundary_detector sfbd_checker u_sfbd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_data_byte   (m_data_byte),
    .m_frame_first (m_frame_first),
    .m_frame_last  (m_frame_last),
    .m_header_byte (m_header_byte)
);

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// stream_frame_boundary_detector testbench
// Feeds byte streams in every framing mode and checks the frame marks.
// Length-prefixed frames, MSG command lines with payloads, plain lines and
// noise are sent. Idle and stall patterns change between runs, and the mode
// register is rewritten between them. A local framer model predicts each
// marked byte, and the monitor compares results in order.
// ---------------------------------------------------------------------------
module testbench;

    import sfbd_pkg::*;

    localparam logic [1:0]  MODE_LEN4     = 2'd1;
    localparam logic [1:0]  MODE_TEXT_ALT = 2'd3;
    localparam logic [7:0]  CHAR_VT       = 8'h0B;
    localparam logic [7:0]  CHAR_FF       = 8'h0C;
    localparam logic [23:0] MSG_LOWER     = "msg";
    localparam logic [23:0] MSG_UPPER     = "MSG";
    localparam logic [35:0] COUNT_MAX     = (36'd1 << LENGTH_BITS_DEFAULT) - 36'd1;
    localparam int          RUN_COUNT     = 9;
    localparam int          RUN_BYTES     = 70;
    localparam int          WATCHDOG_MAX  = 20000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          PRINT_MAX     = 20;
    localparam logic [2*RUN_COUNT-1:0] RUN_MODES = {
        MODE_TEXT, MODE_TEXT_ALT, MODE_LEN2, MODE_TEXT, MODE_LEN4,
        MODE_TEXT_ALT, MODE_TEXT, MODE_LEN4, MODE_LEN2
    };

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       hdr;
    } marked_byte_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_data = 2'd0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_byte_value = 8'd0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_data_byte;
    logic       m_frame_first;
    logic       m_frame_last;
    logic       m_header_byte;

    logic [7:0]   stream_bytes[$];
    marked_byte_t expected_marks[$];
    int           queued_count = 0;
    int           fail_count = 0;
    int           results_seen = 0;
    int           quiet_cycles = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;

    // framer model state
    logic [1:0]  frame_mode;
    phase_t      frm_phase;
    logic [2:0]  hdr_pos;
    logic [31:0] len_acc;
    logic [32:0] body_left;
    logic        prev_cr;
    logic        msg_prefix;
    logic [2:0]  tok_cnt;
    logic        in_tok;
    logic        digits_ok;
    logic [31:0] tok3_val;
    logic [31:0] tok4_val;

    stream_frame_boundary_detector i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_byte_value  (s_byte_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data_byte   (m_data_byte),
        .m_frame_first (m_frame_first),
        .m_frame_last  (m_frame_last),
        .m_header_byte (m_header_byte)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // framer model
    // ------------------------------------------------------------------
    function automatic void clear_frame_state();
        frm_phase  = PH_IDLE;
        hdr_pos    = 3'd0;
        len_acc    = 32'd0;
        body_left  = 33'd0;
        prev_cr    = 1'b0;
        msg_prefix = 1'b0;
        tok_cnt    = 3'd0;
        in_tok     = 1'b0;
        digits_ok  = 1'b0;
        tok3_val   = 32'd0;
        tok4_val   = 32'd0;
    endfunction

    function automatic logic [31:0] decimal_push(input logic [31:0] acc, input logic [7:0] ch);
        logic [35:0] sum;
        sum = {4'd0, acc} * 36'd10 + {28'd0, ch - CHAR_ZERO};
        return (sum > COUNT_MAX) ? COUNT_MAX[31:0] : sum[31:0];
    endfunction

    function automatic void scan_token(input logic [7:0] b);
        if (b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR)) begin
            in_tok = 1'b0;
        end else begin
            if (!in_tok) begin
                in_tok    = 1'b1;
                digits_ok = 1'b1;
                if (tok_cnt < TOKEN_MAX) tok_cnt = tok_cnt + 3'd1;
            end
            if (digits_ok && (tok_cnt == TOKEN_THIRD || tok_cnt == TOKEN_FOURTH)) begin
                if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                    if (tok_cnt == TOKEN_THIRD) tok3_val = decimal_push(tok3_val, b);
                    else tok4_val = decimal_push(tok4_val, b);
                end else begin
                    digits_ok = 1'b0;
                end
            end
        end
    endfunction

    function automatic marked_byte_t mark_byte(input logic [7:0] b);
        marked_byte_t r;
        logic [2:0]   hdr_need;
        logic [31:0]  count;
        r = '{data: b, first: 1'b0, last: 1'b0, hdr: 1'b0};
        hdr_need = (frame_mode == MODE_LEN2) ? HDR_LEN2 : HDR_LEN4;
        if (frm_phase == PH_IDLE) begin
            clear_frame_state();
            r.first = 1'b1;
            if (frame_mode >= MODE_TEXT) begin
                frm_phase  = PH_LINE;
                msg_prefix = 1'b1;
            end else begin
                frm_phase = PH_HEADER;
            end
        end
        case (frm_phase)
            PH_HEADER: begin
                r.hdr   = 1'b1;
                len_acc = {len_acc[23:0], b};
                hdr_pos = hdr_pos + 3'd1;
                if (hdr_pos >= hdr_need) begin
                    if (len_acc == 32'd0) begin
                        r.last    = 1'b1;
                        frm_phase = PH_IDLE;
                    end else begin
                        body_left = {1'b0, len_acc};
                        frm_phase = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                if (body_left != 33'd0) body_left = body_left - 33'd1;
                if (body_left == 33'd0) begin
                    r.last    = 1'b1;
                    frm_phase = PH_IDLE;
                end
            end
            default: begin
                r.hdr = 1'b1;
                if (prev_cr && b == CHAR_LF) begin
                    prev_cr = 1'b0;
                    if (msg_prefix) begin
                        count     = (tok_cnt >= TOKEN_FOURTH) ? tok4_val : tok3_val;
                        body_left = {1'b0, count} + MSG_TRAILER;
                        frm_phase = PH_BODY;
                    end else begin
                        r.last    = 1'b1;
                        frm_phase = PH_IDLE;
                    end
                end else begin
                    if (hdr_pos < PREFIX_LEN) begin
                        if ((b | CASE_BIT) != MSG_LOWER[8*(2 - hdr_pos) +: 8])
                            msg_prefix = 1'b0;
                        hdr_pos = hdr_pos + 3'd1;
                    end else if (msg_prefix) begin
                        scan_token(b);
                    end
                    prev_cr = (b == CHAR_CR);
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stream generation
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b);
        stream_bytes.push_back(b);
        queued_count++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic push_space();
        repeat ($urandom_range(3) == 0 ? 2 : 1) begin
            case ($urandom_range(0, 5))
                0: push_byte(CHAR_SPACE);
                1: push_byte(CHAR_TAB);
                2: push_byte(CHAR_VT);
                3: push_byte(CHAR_FF);
                4: push_byte(CHAR_LF);
                default: begin
                    // lone CR, never followed by LF
                    push_byte(CHAR_CR);
                    push_byte(CHAR_SPACE);
                end
            endcase
        end
    endtask

    task automatic push_word();
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(33, 126)));
    endtask

    task automatic push_huge_count();
        push_byte(8'(CHAR_ZERO + $urandom_range(1, 9)));
        repeat ($urandom_range(10, 11)) push_byte(8'(CHAR_ZERO + $urandom_range(0, 9)));
    endtask

    task automatic push_count(input bit allow_sat, output int unsigned value);
        int kind;
        kind  = $urandom_range(0, 9);
        value = 0;
        if (allow_sat && kind == 0) begin
            push_huge_count();
        end else if (kind == 1) begin
            push_byte(8'("a" + $urandom_range(0, 25)));
            push_word();
        end else begin
            value = $urandom_range(0, 15);
            repeat ($urandom_range(0, 1)) push_byte(CHAR_ZERO);
            push_text($sformatf("%0d", value));
            if (kind == 2) push_byte(8'("A" + $urandom_range(0, 25)));
        end
    endtask

    // huge: the count is saturated and the payload is cut off by a mode write
    task automatic add_msg_frame(input bit huge);
        int          ntok;
        bit          glued;
        int unsigned v3;
        int unsigned v4;
        int unsigned pay;
        ntok  = huge ? $urandom_range(3, 4) : $urandom_range(0, 6);
        glued = ($urandom_range(3) == 0);
        v3    = 0;
        v4    = 0;
        for (int t = 0; t < 3; t++)
            push_byte(MSG_UPPER[8*(2 - t) +: 8] ^ ($urandom_range(1) ? CASE_BIT : 8'h00));
        for (int t = 1; t <= ntok; t++) begin
            if (!(glued && t == 1)) push_space();
            if (huge && t == ntok) push_huge_count();
            else if (t == 3) push_count(ntok >= 4, v3);
            else if (t == 4) push_count(1'b0, v4);
            else push_word();
        end
        if ($urandom_range(3) == 0) push_space();
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
        pay = huge ? $urandom_range(1, 4) : ((ntok >= 4) ? v4 : v3) + MSG_TRAILER;
        repeat (pay) push_byte(8'($urandom_range(255)));
    endtask

    task automatic add_plain_line(input bit near_miss);
        logic [7:0] b;
        if (near_miss) begin
            push_byte("M" ^ ($urandom_range(1) ? CASE_BIT : 8'h00));
            push_byte("S" ^ ($urandom_range(1) ? CASE_BIT : 8'h00));
            do b = 8'($urandom_range(33, 126)); while ((b | CASE_BIT) == "g");
            push_byte(b);
            push_space();
            push_text($sformatf("%0d", $urandom_range(0, 99)));
        end else begin
            do b = 8'($urandom_range(33, 126)); while ((b | CASE_BIT) == "m");
            push_byte(b);
            repeat ($urandom_range(0, 10)) begin
                do b = 8'($urandom_range(255)); while (b == CHAR_CR);
                push_byte(b);
            end
        end
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
    endtask

    task automatic add_length_frame(input bit hdr4, input bit huge);
        logic [31:0] len;
        if (huge) len = hdr4 ? (32'h8000_0000 | $urandom) : (32'h8000 | $urandom_range(16'hFFFF));
        else if ($urandom_range(7) == 0) len = 32'd0;
        else if ($urandom_range(7) == 0) len = $urandom_range(13, 40);
        else len = $urandom_range(1, 12);
        if (hdr4) begin
            push_byte(len[31:24]);
            push_byte(len[23:16]);
        end
        push_byte(len[15:8]);
        push_byte(len[7:0]);
        repeat (huge ? $urandom_range(1, 5) : len) push_byte(8'($urandom_range(255)));
    endtask

    task automatic add_frame(input logic [1:0] mode, input bit huge);
        int pick;
        pick = $urandom_range(0, 9);
        if (mode == MODE_LEN2) add_length_frame(1'b0, huge);
        else if (mode == MODE_LEN4) add_length_frame(1'b1, huge);
        else if (huge || pick < 6) add_msg_frame(huge);
        else if (pick < 8) add_plain_line(1'b0);
        else if (pick < 9) add_plain_line(1'b1);
        else repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(255)));
    endtask

    task automatic fill_stream(input logic [1:0] mode, input int count, input bit tail);
        int target;
        target = queued_count + count;
        while (queued_count < target) add_frame(mode, 1'b0);
        if (tail) add_frame(mode, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // sequencing
    // ------------------------------------------------------------------
    task automatic wait_drained();
        while (stream_bytes.size() != 0 || s_valid || expected_marks.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_mode(input logic [1:0] mode);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        frame_mode = mode;
        clear_frame_state();
    endtask

    task automatic set_idle(input int setting);
        case (setting)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
        endcase
    endtask

    task automatic report_mismatch(input string what);
        if (fail_count < PRINT_MAX) $display("ERROR: result %0d: %s", results_seen, what);
        fail_count++;
    endtask

    task automatic check_marked_byte();
        marked_byte_t want;
        if (expected_marks.size() == 0) begin
            report_mismatch($sformatf("byte 0x%02h with no request pending", m_data_byte));
        end else begin
            want = expected_marks.pop_front();
            if (m_data_byte !== want.data)
                report_mismatch($sformatf("data_byte 0x%02h, expected 0x%02h",
                                          m_data_byte, want.data));
            if (m_frame_first !== want.first)
                report_mismatch($sformatf("frame_first %b, expected %b",
                                          m_frame_first, want.first));
            if (m_frame_last !== want.last)
                report_mismatch($sformatf("frame_last %b, expected %b",
                                          m_frame_last, want.last));
            if (m_header_byte !== want.hdr)
                report_mismatch($sformatf("header_byte %b, expected %b",
                                          m_header_byte, want.hdr));
        end
        results_seen++;
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) expected_marks.push_back(mark_byte(s_byte_value));
            if (!s_valid || s_ready) begin
                if (stream_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid      <= 1'b1;
                    s_byte_value <= stream_bytes.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) check_marked_byte();
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("ERROR: no handshake for %0d cycles", quiet_cycles);
                $display("Simulation FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        frame_mode = MODE_LEN2;
        clear_frame_state();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_idle(0);

        // zero length header, then a one-byte body
        write_mode(MODE_LEN2);
        push_byte(8'h00); push_byte(8'h00);
        push_byte(8'h00); push_byte(8'h01); push_byte(8'hFF);

        // largest four-byte length, dropped by the next mode write
        write_mode(MODE_LEN4);
        repeat (4) push_byte(8'hFF);
        push_byte(8'h00); push_byte(8'h7F);

        // unused mode as text: odd whitespace, too few tokens, a payload of only the trailer
        write_mode(MODE_TEXT_ALT);
        push_text("MsG");
        push_byte(CHAR_VT);
        push_text("1");
        push_byte(CHAR_FF);
        push_text("2");
        push_byte(CHAR_CR); push_byte(CHAR_LF);
        push_byte(CHAR_CR); push_byte(CHAR_LF);

        for (int p = 0; p < RUN_COUNT; p++) begin
            write_mode(RUN_MODES[2*p +: 2]);
            set_idle(p % 4);
            if (p % 3 == 1) begin
                // sender holds off until every result is back
                fill_stream(RUN_MODES[2*p +: 2], RUN_BYTES / 2, 1'b0);
                wait_drained();
                fill_stream(RUN_MODES[2*p +: 2], RUN_BYTES / 2, p % 2 == 0);
            end else begin
                fill_stream(RUN_MODES[2*p +: 2], RUN_BYTES, p % 2 == 0 && p < RUN_COUNT - 1);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
